[rtl/gthq_pkg.sv]
// Package for the grid terrain height query block.
// Field widths, the item kind codes and the query context struct.
// No dependencies.
package gthq_pkg;

   localparam int GRID_SIDE_DEF = 256;

   localparam int TILE_W   = 8;
   localparam int IDX_W    = 16;
   localparam int SAMPLE_W = 8;
   localparam int POS_W    = 18;
   localparam int FRAC_W   = 8;
   localparam int HEIGHT_W = 16;

   localparam logic [TILE_W-1:0] TILE_RESET = 8'd255;

   typedef enum logic {
      ACT_LOAD  = 1'b0,
      ACT_QUERY = 1'b1
   } action_type;

   typedef struct packed {
      logic              in_range;
      logic [FRAC_W-1:0] fx;
      logic [FRAC_W-1:0] fz;
   } qctx_type;

endpackage

[rtl/gthq_ram.sv]
// Generic RAM: one write port, two read ports, registered read data.
// Standalone; no package.
module gthq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

[rtl/gthq_front.sv]
// Front stage: range check, cell split and row base, then store write
// and corner addresses. Depends on gthq_pkg.
module gthq_front #(
   parameter int GRID_SIDE = gthq_pkg::GRID_SIDE_DEF,
   parameter int DEPTH     = GRID_SIDE * GRID_SIDE,
   parameter int AW        = $clog2(DEPTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          s1_en,
   input  logic                          accept,
   input  logic [gthq_pkg::TILE_W-1:0]   tile_count,
   input  gthq_pkg::action_type          action,
   input  logic [gthq_pkg::IDX_W-1:0]    sample_index,
   input  logic [gthq_pkg::SAMPLE_W-1:0] sample_value,
   input  logic [gthq_pkg::POS_W-1:0]    pos_x,
   input  logic [gthq_pkg::POS_W-1:0]    pos_z,
   output logic                          s1_query,
   output logic                          wr_en,
   output logic [AW-1:0]                 wr_addr,
   output logic [gthq_pkg::SAMPLE_W-1:0] wr_data,
   output logic [AW-1:0]                 addr0,
   output logic [AW-1:0]                 addr1,
   output logic [AW-1:0]                 addr2,
   output logic [AW-1:0]                 addr3,
   output gthq_pkg::qctx_type            ctx
);
   import gthq_pkg::*;

   logic [TILE_W-1:0]   tiles;
   logic [16:0]         lim;
   logic                x_ok;
   logic                z_ok;
   logic [TILE_W:0]     side;
   logic [16:0]         prod;

   logic                v1_ff, v1_in;
   logic                ld_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic [SAMPLE_W-1:0] val_ff;
   logic [AW-1:0]       base_ff;
   logic [TILE_W:0]     side_ff;
   logic [7:0]          col_ff;
   qctx_type            ctx_ff, ctx_in;

   logic [AW-1:0]       a0, a1;

   assign tiles = (tile_count > TILE_W'(GRID_SIDE - 1)) ? TILE_W'(GRID_SIDE - 1) : tile_count;
   assign lim   = {1'b0, tiles, 8'h00};
   assign x_ok  = !pos_x[POS_W-1] && (pos_x[16:0] < lim);
   assign z_ok  = !pos_z[POS_W-1] && (pos_z[16:0] < lim);
   assign side  = {1'b0, tiles} + 9'd1;
   assign prod  = 17'(pos_z[15:8]) * 17'(side);

   assign ctx_in.in_range = x_ok && z_ok;
   assign ctx_in.fx       = pos_x[FRAC_W-1:0];
   assign ctx_in.fz       = pos_z[FRAC_W-1:0];

   assign v1_in = s1_en ? accept : v1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         ld_ff   <= (action == ACT_LOAD);
         idx_ff  <= sample_index;
         val_ff  <= sample_value;
         base_ff <= prod[AW-1:0];
         side_ff <= side;
         col_ff  <= pos_x[15:8];
         ctx_ff  <= ctx_in;
      end
   end

   assign s1_query = v1_ff && !ld_ff;

   // loads beyond the store are dropped
   assign wr_en   = v1_ff && ld_ff && ({1'b0, idx_ff} < 17'(DEPTH));
   assign wr_addr = idx_ff[AW-1:0];
   assign wr_data = val_ff;

   assign a0 = ctx_ff.in_range ? base_ff + AW'(col_ff) : '0;
   assign a1 = ctx_ff.in_range ? base_ff + AW'(side_ff) + AW'(col_ff) : '0;

   assign addr0 = a0;
   assign addr1 = a1;
   assign addr2 = ctx_ff.in_range ? a0 + AW'(1) : '0;
   assign addr3 = ctx_ff.in_range ? a1 + AW'(1) : '0;
   assign ctx   = ctx_ff;

endmodule

[rtl/gthq_blend.sv]
// Triangle blend: picks the triangle, forms the two weighted differences,
// sums them onto the base corner and holds the result. Depends on gthq_pkg.
module gthq_blend (
   input  logic                          clock,
   input  logic                          en2,
   input  logic                          en3,
   input  logic                          en_out,
   input  gthq_pkg::qctx_type            ctx,
   input  logic [gthq_pkg::SAMPLE_W-1:0] h0,
   input  logic [gthq_pkg::SAMPLE_W-1:0] h1,
   input  logic [gthq_pkg::SAMPLE_W-1:0] h2,
   input  logic [gthq_pkg::SAMPLE_W-1:0] h3,
   output logic [gthq_pkg::HEIGHT_W-1:0] height,
   output logic                          in_range
);
   import gthq_pkg::*;

   qctx_type             ctx2_ff;
   logic [FRAC_W:0]      fsum;
   logic                 lower;
   logic [SAMPLE_W-1:0]  hb;
   logic [FRAC_W:0]      wa, wb;
   logic signed [8:0]    d1, d2;
   logic signed [18:0]   p1_in, p2_in;

   logic signed [18:0]   p1_ff, p2_ff;
   logic [SAMPLE_W-1:0]  hb_ff;
   logic                 inr3_ff;
   logic signed [19:0]   sum;

   logic [HEIGHT_W-1:0]  height_ff, height_in;
   logic                 in_range_ff;

   always_ff @(posedge clock) begin
      if (en2) begin
         ctx2_ff <= ctx;
      end
   end

   assign fsum  = {1'b0, ctx2_ff.fx} + {1'b0, ctx2_ff.fz};
   assign lower = !fsum[FRAC_W];
   assign hb    = lower ? h0 : h3;
   assign wa    = lower ? {1'b0, ctx2_ff.fz} : 9'd256 - {1'b0, ctx2_ff.fx};
   assign wb    = lower ? {1'b0, ctx2_ff.fx} : 9'd256 - {1'b0, ctx2_ff.fz};
   assign d1    = $signed({1'b0, h1}) - $signed({1'b0, hb});
   assign d2    = $signed({1'b0, h2}) - $signed({1'b0, hb});
   assign p1_in = d1 * $signed({1'b0, wa});
   assign p2_in = d2 * $signed({1'b0, wb});

   always_ff @(posedge clock) begin
      if (en3) begin
         p1_ff   <= p1_in;
         p2_ff   <= p2_in;
         hb_ff   <= hb;
         inr3_ff <= ctx2_ff.in_range;
      end
   end

   assign sum       = $signed({4'b0, hb_ff, 8'h00}) + 20'(p1_ff) + 20'(p2_ff);
   assign height_in = inr3_ff ? sum[HEIGHT_W-1:0] : '0;

   always_ff @(posedge clock) begin
      if (en_out) begin
         height_ff   <= height_in;
         in_range_ff <= inr3_ff;
      end
   end

   assign height   = height_ff;
   assign in_range = in_range_ff;

endmodule

[rtl/grid_terrain_height_query_top.sv]
// Grid terrain height query, top level. A query beat passes the front registers at
// accept, then the store read, the products and the sum registers before it shows on rsp.
// Throughput: one beat per cycle while rsp does not stall; the two store copies give
// four reads a cycle. Loads give no result. Reset clears the pipeline valids
// and sets tile_count to 255; the height store is not cleared.
// Depends on gthq_pkg, gthq_ram, gthq_front, gthq_blend.
module grid_terrain_height_query_top #(
   parameter int GRID_SIDE = gthq_pkg::GRID_SIDE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // sample_index[15:0], sample_value[23:16],
                                   // pos_x[41:24], pos_z[59:42], zero pad
   input  logic [0:0]  req_tuser,  // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // height
   output logic [0:0]  rsp_tuser,  // in_range
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data    // tile_count
);
   import gthq_pkg::*;

   localparam int DEPTH = GRID_SIDE * GRID_SIDE;
   localparam int AW    = $clog2(DEPTH);

   logic [TILE_W-1:0]   tile_count_ff;
   logic                v2_ff, v2_in;
   logic                v3_ff, v3_in;
   logic                out_v_ff, out_v_in;
   logic                free_out, free3, free2, free1;
   logic                accept;

   logic                s1_query;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [SAMPLE_W-1:0] wr_data;
   logic [AW-1:0]       addr0, addr1, addr2, addr3;
   qctx_type            ctx;
   logic [SAMPLE_W-1:0] h0, h1, h2, h3;
   logic [HEIGHT_W-1:0] height;
   logic                in_range;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_count_ff <= TILE_RESET;
      end else if (csr_valid) begin
         tile_count_ff <= csr_data;
      end
   end

   assign free_out   = !out_v_ff || rsp_tready;
   assign free3      = !v3_ff || free_out;
   assign free2      = !v2_ff || free3;
   assign free1      = !s1_query || free2;
   assign req_tready = free1;
   assign accept     = req_tvalid && free1;

   assign v2_in    = free2 ? s1_query : v2_ff;
   assign v3_in    = free3 ? v2_ff : v3_ff;
   assign out_v_in = free_out ? v3_ff : out_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         v2_ff    <= v2_in;
         v3_ff    <= v3_in;
         out_v_ff <= out_v_in;
      end
   end

   gthq_front #(
      .GRID_SIDE (GRID_SIDE),
      .DEPTH     (DEPTH),
      .AW        (AW)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .s1_en        (free1),
      .accept       (accept),
      .tile_count   (tile_count_ff),
      .action       (action_type'(req_tuser[0])),
      .sample_index (req_tdata[15:0]),
      .sample_value (req_tdata[23:16]),
      .pos_x        (req_tdata[41:24]),
      .pos_z        (req_tdata[59:42]),
      .s1_query     (s1_query),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .addr0        (addr0),
      .addr1        (addr1),
      .addr2        (addr2),
      .addr3        (addr3),
      .ctx          (ctx)
   );

   // copy A serves the diagonal corners, copy B the two side corners
   gthq_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (DEPTH)
   ) u_ram_a (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (free2),
      .rd_addr_a (addr0),
      .rd_addr_b (addr3),
      .rd_data_a (h0),
      .rd_data_b (h3)
   );

   gthq_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (DEPTH)
   ) u_ram_b (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (free2),
      .rd_addr_a (addr1),
      .rd_addr_b (addr2),
      .rd_data_a (h1),
      .rd_data_b (h2)
   );

   gthq_blend u_blend (
      .clock    (clock),
      .en2      (free2),
      .en3      (free3),
      .en_out   (free_out),
      .ctx      (ctx),
      .h0       (h0),
      .h1       (h1),
      .h2       (h2),
      .h3       (h3),
      .height   (height),
      .in_range (in_range)
   );

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = height;
   assign rsp_tuser  = in_range;

`ifndef SYNTHESIS
   a_out_of_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 16'h0000)
      else $error("out-of-range beat with nonzero height");

   a_height_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata <= 16'hFF00)
      else $error("height above largest sample");

   a_stall_only_from_rsp: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("req stalled without rsp backpressure");
`endif

endmodule
